// File: rtl/nwlt_pkg.sv
// ----------------------------------------------------------------------------
// nwlt_pkg
// Shared types, codes and sizes for the named wake-lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package nwlt_pkg;

   // Table size default and fixed field widths
   localparam int SLOTS_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int KEY_W         = 64;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int SLOT_OUT_W    = 4;
   localparam int COUNT_OUT_W   = 5;
   localparam int USER_W        = 2;
   localparam int REQUEST_W     = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ACQ_PARTIAL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQ_FULL    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STANDBY     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WAKE        = 3'd4;

   // Lock modes held in a slot
   localparam logic [MODE_W-1:0] MODE_INACTIVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PARTIAL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FULL     = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_SAME     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_INACTIVE = 3'd6;

   // User states
   localparam logic [USER_W-1:0] UMODE_AWAKE  = 2'd0;
   localparam logic [USER_W-1:0] UMODE_NOTIFY = 2'd1;
   localparam logic [USER_W-1:0] UMODE_SLEEP  = 2'd2;

   // Suspend requests
   localparam logic [REQUEST_W-1:0] REQ_NONE    = 2'd0;
   localparam logic [REQUEST_W-1:0] REQ_STANDBY = 2'd1;
   localparam logic [REQUEST_W-1:0] REQ_WAKE    = 2'd2;

   // One slot of the table
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [MODE_W-1:0] mode;
   } entry_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

endpackage : nwlt_pkg

`default_nettype wire

// File: rtl/nwlt_store.sv
// ----------------------------------------------------------------------------
// nwlt_store
// Slot memory: one write port, one read port with registered data.
// Per-entry valid bits make never-written slots read as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_store #(
   parameter int SLOTS = nwlt_pkg::SLOTS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(SLOTS)-1:0]    rd_addr,
   output nwlt_pkg::entry_type              rd_data,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  wire nwlt_pkg::entry_type         wr_data
);

   nwlt_pkg::entry_type mem [SLOTS];
   nwlt_pkg::entry_type rd_data_ff;
   logic [SLOTS-1:0]    valid_ff;
   logic                rd_valid_ff;

   // Write the array and capture read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Track written entries; reset empties the table
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Unwritten entries read as empty, inactive
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule : nwlt_store

`default_nettype wire

// File: rtl/nwlt_ctrl.sv
// ----------------------------------------------------------------------------
// nwlt_ctrl
// Sequencer: scans the slot memory, decides the command, writes back at most one
// entry, keeps counts and user state, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_ctrl #(
   parameter int SLOTS = nwlt_pkg::SLOTS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [nwlt_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [nwlt_pkg::KEY_W-1:0]           req_lock_key,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [nwlt_pkg::STATUS_W-1:0]             rsp_status,
   output logic [nwlt_pkg::SLOT_OUT_W-1:0]           rsp_slot_index,
   output logic [nwlt_pkg::COUNT_OUT_W-1:0]          rsp_full_count,
   output logic [nwlt_pkg::COUNT_OUT_W-1:0]          rsp_partial_count,
   output logic [nwlt_pkg::USER_W-1:0]               rsp_user_mode,
   output logic [nwlt_pkg::REQUEST_W-1:0]            rsp_suspend_request,
   output logic                                      rsp_any_lock_held,
   output logic                                      rd_en,
   output logic [$clog2(SLOTS)-1:0]                  rd_addr,
   input  wire nwlt_pkg::entry_type                  rd_data,
   output logic                                      wr_en,
   output logic [$clog2(SLOTS)-1:0]                  wr_addr,
   output nwlt_pkg::entry_type                       wr_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   nwlt_pkg::state_type state_ff, state_in;

   // Command word
   logic [nwlt_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [nwlt_pkg::KEY_W-1:0] key_ff, key_in;

   // Scan pipeline
   logic [IW-1:0] scan_ff, scan_in;
   logic          issue_ff, issue_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;

   // Scan findings
   logic                        hit_ff, hit_in;
   logic [IW-1:0]               hit_idx_ff, hit_idx_in;
   logic [nwlt_pkg::MODE_W-1:0] hit_mode_ff, hit_mode_in;
   logic                        empty_ok_ff, empty_ok_in;
   logic [IW-1:0]               empty_idx_ff, empty_idx_in;
   logic                        idle_ok_ff, idle_ok_in;
   logic [IW-1:0]               idle_idx_ff, idle_idx_in;

   // Architectural state
   logic [CW-1:0]               full_ff, full_in;
   logic [CW-1:0]               partial_ff, partial_in;
   logic [nwlt_pkg::USER_W-1:0] user_ff, user_in;

   // Result word
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nwlt_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [IW-1:0]                  slot_ff, slot_in;
   logic [nwlt_pkg::REQUEST_W-1:0] request_ff, request_in;

   // Handshake helpers
   logic accept;
   logic lookup;
   logic out_free;
   logic retire;

   // Decision outputs
   logic                        dec_wr;
   logic [IW-1:0]               dec_addr;
   logic [nwlt_pkg::MODE_W-1:0] dec_mode;

   assign accept   = req_valid && req_ready;
   assign lookup   = (req_cmd <= nwlt_pkg::CMD_RELEASE) && (req_lock_key != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nwlt_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = lookup ? nwlt_pkg::S_SCAN : nwlt_pkg::S_DECIDE;
            end
         end
         nwlt_pkg::S_SCAN: begin
            if (cmp_vld_ff && (cmp_idx_ff == LAST)) begin
               state_in = nwlt_pkg::S_DECIDE;
            end
         end
         nwlt_pkg::S_DECIDE: begin
            if (out_free) begin
               state_in = nwlt_pkg::S_IDLE;
            end
         end
         default: state_in = nwlt_pkg::S_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      retire    = 1'b0;
      unique case (state_ff)
         nwlt_pkg::S_IDLE:   req_ready = 1'b1;
         nwlt_pkg::S_SCAN:   rd_en     = issue_ff;
         nwlt_pkg::S_DECIDE: retire    = out_free;
         default: ;
      endcase
   end

   assign rd_addr = scan_ff;

   // Advance the scan and collect first hit, first empty, first inactive
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = rd_en;
      cmp_idx_in   = scan_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mode_in  = hit_mode_ff;
      empty_ok_in  = empty_ok_ff;
      empty_idx_in = empty_idx_ff;
      idle_ok_in   = idle_ok_ff;
      idle_idx_in  = idle_idx_ff;

      if (accept) begin
         cmd_in      = req_cmd;
         key_in      = req_lock_key;
         scan_in     = '0;
         issue_in    = lookup;
         hit_in      = 1'b0;
         empty_ok_in = 1'b0;
         idle_ok_in  = 1'b0;
      end

      if (rd_en) begin
         scan_in = scan_ff + IW'(1);
         if (scan_ff == LAST) begin
            issue_in = 1'b0;
         end
      end

      if (cmp_vld_ff) begin
         if (rd_data.key != '0) begin
            if ((rd_data.key == key_ff) && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_mode_in = rd_data.mode;
            end else if ((rd_data.mode == nwlt_pkg::MODE_INACTIVE) && !idle_ok_ff) begin
               idle_ok_in  = 1'b1;
               idle_idx_in = cmp_idx_ff;
            end
         end else if (!empty_ok_ff) begin
            empty_ok_in  = 1'b1;
            empty_idx_in = cmp_idx_ff;
         end
      end
   end

   // Decide the command and form the result
   always_comb begin
      logic                        is_acq;
      logic [nwlt_pkg::MODE_W-1:0] want;
      logic [nwlt_pkg::MODE_W-1:0] cur;
      logic                        target_ok;
      logic [IW-1:0]               target;

      is_acq    = (cmd_ff == nwlt_pkg::CMD_ACQ_PARTIAL) || (cmd_ff == nwlt_pkg::CMD_ACQ_FULL);
      want      = (cmd_ff == nwlt_pkg::CMD_ACQ_FULL) ? nwlt_pkg::MODE_FULL
                                                     : nwlt_pkg::MODE_PARTIAL;
      cur       = hit_ff ? hit_mode_ff : nwlt_pkg::MODE_INACTIVE;
      target_ok = hit_ff || empty_ok_ff || idle_ok_ff;
      priority if (hit_ff)      target = hit_idx_ff;
      else if (empty_ok_ff)     target = empty_idx_ff;
      else                      target = idle_idx_ff;

      status_in  = nwlt_pkg::STAT_OK;
      slot_in    = '0;
      request_in = nwlt_pkg::REQ_NONE;
      full_in    = full_ff;
      partial_in = partial_ff;
      user_in    = user_ff;
      dec_wr     = 1'b0;
      dec_addr   = target;
      dec_mode   = nwlt_pkg::MODE_INACTIVE;

      priority if ((is_acq || (cmd_ff == nwlt_pkg::CMD_RELEASE)) && (key_ff == '0)) begin
         status_in = nwlt_pkg::STAT_EMPTY;
      end else if (cmd_ff == nwlt_pkg::CMD_RELEASE) begin
         if (!hit_ff) begin
            status_in = nwlt_pkg::STAT_NOTFOUND;
         end else begin
            slot_in = hit_idx_ff;
            if (hit_mode_ff == nwlt_pkg::MODE_INACTIVE) begin
               status_in = nwlt_pkg::STAT_INACTIVE;
            end else begin
               dec_wr   = 1'b1;
               dec_mode = nwlt_pkg::MODE_INACTIVE;
               if (hit_mode_ff == nwlt_pkg::MODE_FULL) begin
                  if (full_ff != '0) begin
                     full_in = full_ff - CW'(1);
                  end
                  if ((full_in == '0) && (user_ff == nwlt_pkg::UMODE_NOTIFY)) begin
                     user_in    = nwlt_pkg::UMODE_SLEEP;
                     request_in = nwlt_pkg::REQ_STANDBY;
                  end
               end else if (hit_mode_ff == nwlt_pkg::MODE_PARTIAL) begin
                  if (partial_ff != '0) begin
                     partial_in = partial_ff - CW'(1);
                  end
               end
            end
         end
      end else if (is_acq) begin
         if (!target_ok) begin
            status_in = nwlt_pkg::STAT_NOSPACE;
         end else begin
            slot_in = target;
            priority if (cur == want) begin
               status_in = nwlt_pkg::STAT_SAME;
            end else if (cur != nwlt_pkg::MODE_INACTIVE) begin
               status_in = nwlt_pkg::STAT_BUSY;
            end else begin
               dec_wr   = 1'b1;
               dec_mode = want;
               if (want == nwlt_pkg::MODE_FULL) begin
                  full_in = full_ff + CW'(1);
               end else begin
                  partial_in = partial_ff + CW'(1);
               end
            end
         end
      end else if (cmd_ff == nwlt_pkg::CMD_STANDBY) begin
         user_in    = nwlt_pkg::UMODE_SLEEP;
         request_in = nwlt_pkg::REQ_STANDBY;
      end else if (cmd_ff == nwlt_pkg::CMD_WAKE) begin
         user_in    = nwlt_pkg::UMODE_AWAKE;
         request_in = nwlt_pkg::REQ_WAKE;
      end else begin
         // Status query and unused codes leave the state alone
         status_in = nwlt_pkg::STAT_OK;
      end
   end

   // Write back at most one entry when the decision retires
   assign wr_en        = retire && dec_wr;
   assign wr_addr      = dec_addr;
   assign wr_data.key  = key_ff;
   assign wr_data.mode = dec_mode;

   // Hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (retire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nwlt_pkg::S_IDLE;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         full_ff      <= '0;
         partial_ff   <= '0;
         user_ff      <= nwlt_pkg::UMODE_AWAKE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (retire) begin
            full_ff    <= full_in;
            partial_ff <= partial_in;
            user_ff    <= user_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_mode_ff  <= hit_mode_in;
      empty_ok_ff  <= empty_ok_in;
      empty_idx_ff <= empty_idx_in;
      idle_ok_ff   <= idle_ok_in;
      idle_idx_ff  <= idle_idx_in;
      if (retire) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         request_ff <= request_in;
      end
   end

   // Drive the result channel
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot_index      = nwlt_pkg::SLOT_OUT_W'(slot_ff);
   assign rsp_full_count      = nwlt_pkg::COUNT_OUT_W'(full_ff);
   assign rsp_partial_count   = nwlt_pkg::COUNT_OUT_W'(partial_ff);
   assign rsp_user_mode       = user_ff;
   assign rsp_suspend_request = request_ff;
   assign rsp_any_lock_held   = (full_ff != '0) || (partial_ff != '0);

endmodule : nwlt_ctrl

`default_nettype wire

// File: rtl/named_wake_lock_table_unit.sv
// ----------------------------------------------------------------------------
// named_wake_lock_table_unit
// Table of named wake-lock slots keyed by a 64-bit name.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_cmd, req_lock_key) enter on a valid/ready channel;
//   each gives exactly one response word on the rsp_ channel.
//   Lock commands (acquire partial, acquire full, release) with a nonzero
//   key scan every slot of the slot memory through its single read port,
//   one slot per cycle, then write back at most one entry. Standby, wake,
//   status and empty-name words skip the scan and go straight to the
//   decision. One word is in work at a time. The response sits in an
//   output register; the next request is taken while it waits, and a
//   stalled receiver holds the block only when a second response is
//   ready to be written.
//   Reset (synchronous, active high) empties all slots at once through
//   per-slot valid bits, clears both lock counts and sets the user state
//   to awake; the block takes a request in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module named_wake_lock_table_unit #(
   parameter int SLOTS = nwlt_pkg::SLOTS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [nwlt_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [nwlt_pkg::KEY_W-1:0]           req_lock_key,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [nwlt_pkg::STATUS_W-1:0]             rsp_status,
   output logic [nwlt_pkg::SLOT_OUT_W-1:0]           rsp_slot_index,
   output logic [nwlt_pkg::COUNT_OUT_W-1:0]          rsp_full_count,
   output logic [nwlt_pkg::COUNT_OUT_W-1:0]          rsp_partial_count,
   output logic [nwlt_pkg::USER_W-1:0]               rsp_user_mode,
   output logic [nwlt_pkg::REQUEST_W-1:0]            rsp_suspend_request,
   output logic                                      rsp_any_lock_held
);

   localparam int IW = $clog2(SLOTS);

   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   nwlt_pkg::entry_type rd_data;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   nwlt_pkg::entry_type wr_data;

   // Sequencer and result register
   nwlt_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_lock_key        (req_lock_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_full_count      (rsp_full_count),
      .rsp_partial_count   (rsp_partial_count),
      .rsp_user_mode       (rsp_user_mode),
      .rsp_suspend_request (rsp_suspend_request),
      .rsp_any_lock_held   (rsp_any_lock_held),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data)
   );

   // Slot memory
   nwlt_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule : named_wake_lock_table_unit

`default_nettype wire

// File: tb/sv/named_wake_lock_table_unit_tb.sv
// ----------------------------------------------------------------------------
// named_wake_lock_table_unit_tb
// Self-checking bench for the named wake-lock table.
// ----------------------------------------------------------------------------
// A clocked driver feeds request words from a queue and a clocked monitor
// predicts each accepted word against a private copy of the slot table,
// then checks every response word field by field in order. A directed
// opening covers empty names, repeated and busy acquires, inactive and
// unknown releases, table overflow and every command code. Random phases
// then run over a small key pool with varied sender and receiver idling,
// ending with a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module named_wake_lock_table_unit_tb;

   import nwlt_pkg::*;

   localparam int TABLE_SLOTS  = SLOTS_DEFAULT;
   localparam int KEY_POOL     = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 600000;

   // Command codes without a name in the package
   localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
   } lock_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [COUNT_OUT_W-1:0] full;
      logic [COUNT_OUT_W-1:0] partial;
      logic [USER_W-1:0]      user;
      logic [REQUEST_W-1:0]   request;
      logic                   held;
   } lock_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid    = 1'b0;
   logic                         req_ready;
   logic [CMD_W-1:0]             req_cmd      = '0;
   logic [KEY_W-1:0]             req_lock_key = '0;
   logic                         rsp_valid;
   logic                         rsp_ready    = 1'b0;
   logic [STATUS_W-1:0]          rsp_status;
   logic [SLOT_OUT_W-1:0]        rsp_slot_index;
   logic [COUNT_OUT_W-1:0]       rsp_full_count;
   logic [COUNT_OUT_W-1:0]       rsp_partial_count;
   logic [USER_W-1:0]            rsp_user_mode;
   logic [REQUEST_W-1:0]         rsp_suspend_request;
   logic                         rsp_any_lock_held;

   // Bench-side copy of the lock table
   logic [KEY_W-1:0]  tbl_key  [TABLE_SLOTS];
   logic [MODE_W-1:0] tbl_mode [TABLE_SLOTS];
   int unsigned       full_held;
   int unsigned       partial_held;
   logic [USER_W-1:0] user_now;

   lock_request_type queued_requests[$];
   lock_reply_type   awaited_replies[$];
   lock_request_type next_word;
   lock_reply_type   predicted;
   lock_reply_type   oldest;
   logic [KEY_W-1:0] key_pool [KEY_POOL];

   logic req_taken     = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_len      = 0;
   int   hold_count    = 0;
   int   cycle_count   = 0;
   int   fail_count    = 0;
   int   idx;

   named_wake_lock_table_unit #(
      .SLOTS(TABLE_SLOTS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_lock_key        (req_lock_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_full_count      (rsp_full_count),
      .rsp_partial_count   (rsp_partial_count),
      .rsp_user_mode       (rsp_user_mode),
      .rsp_suspend_request (rsp_suspend_request),
      .rsp_any_lock_held   (rsp_any_lock_held)
   );

   always #5 clock = ~clock;

   // Count the failure and print it
   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string field, input logic [KEY_W-1:0] got,
                              input logic [KEY_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
   endtask

   // Apply one command to the table copy and form the response it gives
   task automatic apply_lock_command(input logic [CMD_W-1:0] cmd,
                                     input logic [KEY_W-1:0] key,
                                     output lock_reply_type r);
      int hit;
      int empty_at;
      int idle_at;
      int sel;
      int k;
      logic [MODE_W-1:0] m;
      logic [MODE_W-1:0] want;
      r = '0;
      r.status = STAT_OK;
      r.request = REQ_NONE;
      hit = -1;
      empty_at = -1;
      idle_at = -1;
      if (cmd == CMD_ACQ_PARTIAL || cmd == CMD_ACQ_FULL || cmd == CMD_RELEASE) begin
         if (key == '0) begin
            r.status = STAT_EMPTY;
         end else begin
            // Find the key, the first empty slot and the first idle one
            for (k = 0; k < TABLE_SLOTS; k++) begin
               if (tbl_key[k] != '0) begin
                  if (tbl_key[k] == key && hit < 0)
                     hit = k;
                  else if (tbl_mode[k] == MODE_INACTIVE && idle_at < 0)
                     idle_at = k;
               end else if (empty_at < 0) begin
                  empty_at = k;
               end
            end
            sel = hit;
            if (sel < 0 && cmd != CMD_RELEASE) begin
               sel = (empty_at >= 0) ? empty_at : idle_at;
               if (sel >= 0) begin
                  tbl_key[sel] = key;
                  tbl_mode[sel] = MODE_INACTIVE;
               end
            end
            if (sel < 0) begin
               r.status = (cmd == CMD_RELEASE) ? STAT_NOTFOUND : STAT_NOSPACE;
            end else begin
               m = tbl_mode[sel];
               r.slot = sel[SLOT_OUT_W-1:0];
               if (cmd == CMD_RELEASE) begin
                  if (m == MODE_INACTIVE) begin
                     r.status = STAT_INACTIVE;
                  end else begin
                     tbl_mode[sel] = MODE_INACTIVE;
                     if (m == MODE_FULL) begin
                        if (full_held > 0)
                           full_held--;
                        // Drop to sleep when the last full lock goes during notify
                        if (full_held == 0 && user_now == UMODE_NOTIFY) begin
                           user_now = UMODE_SLEEP;
                           r.request = REQ_STANDBY;
                        end
                     end else if (m == MODE_PARTIAL) begin
                        if (partial_held > 0)
                           partial_held--;
                     end
                  end
               end else begin
                  want = (cmd == CMD_ACQ_PARTIAL) ? MODE_PARTIAL : MODE_FULL;
                  if (m == want) begin
                     r.status = STAT_SAME;
                  end else if (m != MODE_INACTIVE) begin
                     r.status = STAT_BUSY;
                  end else begin
                     tbl_mode[sel] = want;
                     if (want == MODE_FULL)
                        full_held++;
                     else
                        partial_held++;
                  end
               end
            end
         end
      end else if (cmd == CMD_STANDBY) begin
         user_now = UMODE_SLEEP;
         r.request = REQ_STANDBY;
      end else if (cmd == CMD_WAKE) begin
         user_now = UMODE_AWAKE;
         r.request = REQ_WAKE;
      end
      for (k = 0; k < TABLE_SLOTS; k++)
         if (tbl_mode[k] != MODE_INACTIVE)
            r.held = 1'b1;
      r.full = full_held[COUNT_OUT_W-1:0];
      r.partial = partial_held[COUNT_OUT_W-1:0];
      r.user = user_now;
   endtask

   // Driver: advance to the next queued word once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = queued_requests.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_word.cmd;
            req_lock_key <= next_word.key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, and hold off fully during a hold window
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= (hold_count >= hold_len) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Count out the receiver hold window
   always @(posedge clock) begin
      if (hold_count < hold_len)
         hold_count <= hold_count + 1;
   end

   // Monitor: predict accepted words, check response words in order
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            apply_lock_command(req_cmd, req_lock_key, predicted);
            awaited_replies.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("response word with none awaited");
            end else begin
               oldest = awaited_replies.pop_front();
               check_field("status", KEY_W'(rsp_status), KEY_W'(oldest.status));
               check_field("slot_index", KEY_W'(rsp_slot_index), KEY_W'(oldest.slot));
               check_field("full_count", KEY_W'(rsp_full_count), KEY_W'(oldest.full));
               check_field("partial_count", KEY_W'(rsp_partial_count),
                           KEY_W'(oldest.partial));
               check_field("user_mode", KEY_W'(rsp_user_mode), KEY_W'(oldest.user));
               check_field("suspend_request", KEY_W'(rsp_suspend_request),
                           KEY_W'(oldest.request));
               check_field("any_lock_held", KEY_W'(rsp_any_lock_held),
                           KEY_W'(oldest.held));
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Queue random words for one idling setting, then wait for the drain
   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      lock_request_type word;
      int pick;
      int n;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30)
            word.cmd = CMD_ACQ_PARTIAL;
         else if (pick < 55)
            word.cmd = CMD_ACQ_FULL;
         else if (pick < 85)
            word.cmd = CMD_RELEASE;
         else if (pick < 90)
            word.cmd = CMD_STANDBY;
         else if (pick < 94)
            word.cmd = CMD_WAKE;
         else if (pick < 97)
            word.cmd = CMD_QUERY;
         else if (pick < 99)
            word.cmd = CMD_UNUSED_6;
         else
            word.cmd = CMD_UNUSED_7;
         // Mostly pool keys so lookups hit and the table fills
         pick = $urandom_range(99);
         if (pick < 4)
            word.key = '0;
         else if (pick < 12)
            word.key = {$urandom, $urandom};
         else
            word.key = key_pool[$urandom_range(KEY_POOL - 1)];
         queued_requests.push_back(word);
      end
      while (queued_requests.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      for (idx = 0; idx < TABLE_SLOTS; idx++) begin
         tbl_key[idx] = '0;
         tbl_mode[idx] = MODE_INACTIVE;
      end
      full_held = 0;
      partial_held = 0;
      user_now = UMODE_AWAKE;

      // Build the key pool: extremes, table fillers and random names
      key_pool[0] = '1;
      for (idx = 1; idx <= TABLE_SLOTS; idx++)
         key_pool[idx] = 64'hC3C3_0000_0000_0000 | 64'(idx);
      key_pool[TABLE_SLOTS + 1] = 64'h1;
      key_pool[TABLE_SLOTS + 2] = 64'h8000_0000_0000_0000;
      for (idx = TABLE_SLOTS + 3; idx < KEY_POOL; idx++)
         key_pool[idx] = {$urandom, $urandom} | 64'h100;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty names on every lock command
      queued_requests.push_back('{CMD_ACQ_PARTIAL, '0});
      queued_requests.push_back('{CMD_ACQ_FULL, '0});
      queued_requests.push_back('{CMD_RELEASE, '0});
      // Acquire, repeat, busy, release, inactive release
      queued_requests.push_back('{CMD_ACQ_PARTIAL, key_pool[0]});
      queued_requests.push_back('{CMD_ACQ_PARTIAL, key_pool[0]});
      queued_requests.push_back('{CMD_ACQ_FULL, key_pool[0]});
      queued_requests.push_back('{CMD_RELEASE, key_pool[0]});
      queued_requests.push_back('{CMD_RELEASE, key_pool[0]});
      // Non-lock commands, unused codes included
      queued_requests.push_back('{CMD_STANDBY, '1});
      queued_requests.push_back('{CMD_WAKE, '0});
      queued_requests.push_back('{CMD_QUERY, '0});
      queued_requests.push_back('{CMD_UNUSED_6, '1});
      queued_requests.push_back('{CMD_UNUSED_7, '0});
      // Fill every slot, reusing the idle one last, then overflow
      for (idx = 1; idx <= TABLE_SLOTS; idx++)
         queued_requests.push_back('{CMD_ACQ_FULL, key_pool[idx]});
      queued_requests.push_back('{CMD_ACQ_PARTIAL, key_pool[TABLE_SLOTS + 1]});
      queued_requests.push_back('{CMD_RELEASE, key_pool[0]});

      run_phase(0, 0, 400);
      run_phase(57, 0, 400);
      run_phase(0, 57, 400);
      run_phase(32, 32, 400);

      // Hold the receiver off while the sender keeps offering words
      hold_len <= hold_count + HOLD_CYCLES;
      run_phase(0, 0, 120);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived",
                                   awaited_replies.size()));
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule : named_wake_lock_table_unit_tb

`default_nettype wire

// File: files.f
rtl/nwlt_pkg.sv
rtl/nwlt_store.sv
rtl/nwlt_ctrl.sv
rtl/named_wake_lock_table_unit.sv
tb/sv/named_wake_lock_table_unit_tb.sv
